// ===== rtl/core/sepd_pkg.sv =====
// ----------------------------------------------------------------------------
// sepd_pkg: shared types and constants for the steering error PD drive
// Beat types for both channels, the configuration set, the entry that
// travels between the front and the back, and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package sepd_pkg;

  // One input beat: a pair of pickup readings.
  typedef struct packed {
    logic [7:0] left_sample;
    logic [7:0] right_sample;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic signed [8:0]  steer_error;
    logic signed [15:0] drive_total;
    logic [7:0]         left_duty;
    logic [7:0]         right_duty;
  } out_item_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [7:0] diff_threshold;
    logic [7:0] blank_level;
    logic [6:0] prop_gain;
    logic [5:0] deriv_gain;
    logic [7:0] base_speed;
  } cfg_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic signed [8:0] steer_error;
    logic signed [9:0] err_delta;
    logic [16:0]       divisor;
  } work_t;

  // Register index, taken from the word address.
  localparam int unsigned RegIdxW = 3;
  typedef enum logic [RegIdxW-1:0] {
    REG_DIFF_THRESHOLD = 3'd0,
    REG_BLANK_LEVEL    = 3'd1,
    REG_PROP_GAIN      = 3'd2,
    REG_DERIV_GAIN     = 3'd3,
    REG_BASE_SPEED     = 3'd4
  } reg_idx_e;

  localparam int unsigned PaddrW = 5;

  // Reset values of the registers.
  localparam logic [7:0] DiffThresholdRst = 8'd3;
  localparam logic [7:0] BlankLevelRst    = 8'd20;
  localparam logic [6:0] PropGainRst      = 7'd9;
  localparam logic [5:0] DerivGainRst     = 6'd0;
  localparam logic [7:0] BaseSpeedRst     = 8'd0;

  // Error codes for the lost-line cases.
  localparam logic signed [8:0] ErrLostRight = -9'sd255;
  localparam logic signed [8:0] ErrLostLeft  = 9'sd255;

endpackage

`default_nettype wire

// ===== rtl/core/sepd_front.sv =====
// ----------------------------------------------------------------------------
// sepd_front: sample classification and error history
// Accepts a sample pair, classifies the steering error, keeps the side flags
// and interval counters, and pushes the derivative operands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sepd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sepd_pkg::cfg_t   cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire sepd_pkg::in_item_t in_item_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output sepd_pkg::work_t       q_data_o
);
  import sepd_pkg::*;

  logic signed [8:0] held_q, held_d;
  logic signed [8:0] earlier_q, earlier_d;
  logic              left_seen_q, left_seen_d;
  logic              right_seen_q, right_seen_d;
  logic [15:0]       steps_q, steps_d;
  logic [15:0]       prev_q, prev_d;

  logic              accept;
  logic signed [9:0] diff;
  logic [8:0]        diff_mag;
  logic [8:0]        thr;
  logic              in_band;
  logic              both_lit;
  logic signed [9:0] err_pos, err_neg;
  logic signed [8:0] err;
  logic              flag_l, flag_r;
  logic              changed;
  logic [15:0]       steps_eff;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  assign diff     = $signed({2'b00, in_item_i.left_sample}) -
                    $signed({2'b00, in_item_i.right_sample});
  assign diff_mag = diff[9] ? 9'(-diff) : diff[8:0];
  assign thr      = {1'b0, cfg_i.diff_threshold};
  assign in_band  = diff_mag < thr;
  assign both_lit = (in_item_i.left_sample > cfg_i.blank_level) &&
                    (in_item_i.right_sample > cfg_i.blank_level);
  assign err_pos  = diff - $signed({2'b00, cfg_i.diff_threshold});
  assign err_neg  = diff + $signed({2'b00, cfg_i.diff_threshold});

  // Ordered classification; the first case that matches wins.
  always_comb begin
    err    = held_q;
    flag_l = left_seen_q;
    flag_r = right_seen_q;
    if (in_band && both_lit) begin
      err = '0;
    end else if (in_band && right_seen_q) begin
      err = ErrLostRight;
    end else if (in_band && left_seen_q) begin
      err = ErrLostLeft;
    end else if (!diff[9] && diff_mag > thr) begin
      err    = err_pos[8:0];
      flag_l = 1'b1;
      flag_r = 1'b0;
    end else if (diff[9] && diff_mag > thr) begin
      err    = err_neg[8:0];
      flag_l = 1'b0;
      flag_r = 1'b1;
    end
  end

  assign changed   = err != held_q;
  assign steps_eff = changed ? 16'd1 : steps_q;

  always_comb begin
    held_d       = held_q;
    earlier_d    = earlier_q;
    left_seen_d  = left_seen_q;
    right_seen_d = right_seen_q;
    steps_d      = steps_q;
    prev_d       = prev_q;
    if (accept) begin
      held_d       = err;
      left_seen_d  = flag_l;
      right_seen_d = flag_r;
      if (changed) begin
        earlier_d = held_q;
        prev_d    = steps_q;
      end
      steps_d = (steps_eff == 16'hFFFF) ? steps_eff : steps_eff + 16'd1;
    end
  end

  always_comb begin
    q_data_o.steer_error = err;
    q_data_o.err_delta   = {err[8], err} -
                           (changed ? {held_q[8], held_q} : {earlier_q[8], earlier_q});
    q_data_o.divisor     = {1'b0, steps_eff} + {1'b0, changed ? steps_q : prev_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      earlier_q    <= '0;
      left_seen_q  <= 1'b0;
      right_seen_q <= 1'b0;
      steps_q      <= '0;
      prev_q       <= '0;
    end else begin
      held_q       <= held_d;
      earlier_q    <= earlier_d;
      left_seen_q  <= left_seen_d;
      right_seen_q <= right_seen_d;
      steps_q      <= steps_d;
      prev_q       <= prev_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sepd_queue.sv =====
// ----------------------------------------------------------------------------
// sepd_queue: short work queue between front and back
// A small register FIFO so that classification and arithmetic stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module sepd_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sepd_pkg::work_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output sepd_pkg::work_t      pop_data_o,
  output logic                 empty_o
);
  import sepd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  work_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = count_q == CntW'(Depth);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sepd_back.sv =====
// ----------------------------------------------------------------------------
// sepd_back: PD arithmetic and wheel duties
// Forms the gain products, divides the derivative numerator serially, then
// saturates the total and clamps both duties into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sepd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sepd_pkg::cfg_t  cfg_i,
  input  wire logic            q_empty_i,
  output logic                 q_pop_o,
  input  wire sepd_pkg::work_t q_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sepd_pkg::out_item_t  out_item_o
);
  import sepd_pkg::*;

  localparam int unsigned QuoW = 16;
  localparam int unsigned CntW = $clog2(QuoW);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_TOT  = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  work_t                work_q;
  logic                 neg_q;
  logic signed [15:0]   prod_q;
  logic [QuoW-1:0]      quo_q;
  logic [17:0]          rem_q;
  logic [CntW-1:0]      cnt_q;
  logic signed [15:0]   total_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic signed [16:0]   num;
  logic [16:0]          num_mag;
  logic signed [15:0]   prod;
  logic [17:0]          trial;
  logic                 fits;
  logic [QuoW-1:0]      quo_eff;
  logic signed [17:0]   quo_signed;
  logic signed [17:0]   sum;
  logic signed [15:0]   total_sat;
  logic signed [17:0]   lval, rval;
  logic [7:0]           left_duty, right_duty;
  logic                 out_free;

  assign num     = $signed({1'b0, cfg_i.deriv_gain}) * work_q.err_delta;
  assign num_mag = num[16] ? 17'(-num) : num;
  assign prod    = $signed({1'b0, cfg_i.prop_gain}) * work_q.steer_error;

  // One restoring step per cycle.
  assign trial = {rem_q[16:0], quo_q[QuoW-1]};
  assign fits  = trial >= {1'b0, work_q.divisor};

  // A zero divisor gives a zero derivative term.
  assign quo_eff    = (work_q.divisor == '0) ? '0 : quo_q;
  assign quo_signed = neg_q ? -$signed({2'b00, quo_eff}) : $signed({2'b00, quo_eff});
  assign sum        = {{2{prod_q[15]}}, prod_q} + quo_signed;

  always_comb begin
    if (sum > 18'sd32767) begin
      total_sat = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      total_sat = 16'sh8000;
    end else begin
      total_sat = sum[15:0];
    end
  end

  assign lval = {{2{total_q[15]}}, total_q} - $signed({10'd0, cfg_i.base_speed});
  assign rval = {{2{total_q[15]}}, total_q} + $signed({10'd0, cfg_i.base_speed});

  always_comb begin
    if (lval > 18'sd0) begin
      left_duty = 8'd0;
    end else if (lval < -18'sd255) begin
      left_duty = 8'd255;
    end else begin
      left_duty = 8'(-lval);
    end
    if (rval > 18'sd255) begin
      right_duty = 8'd255;
    end else if (rval < 18'sd0) begin
      right_duty = 8'd0;
    end else begin
      right_duty = rval[7:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CntW'(QuoW - 1)) state_d = ST_TOT;
      end
      ST_TOT: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) work_q <= q_data_i;
      end
      ST_MUL: begin
        prod_q <= prod;
        neg_q  <= num[16];
        quo_q  <= num_mag[QuoW-1:0];
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      ST_DIV: begin
        rem_q <= fits ? trial - {1'b0, work_q.divisor} : trial;
        quo_q <= {quo_q[QuoW-2:0], fits};
        cnt_q <= cnt_q + CntW'(1);
      end
      ST_TOT: total_q <= total_sat;
      ST_OUT: begin
        if (out_free) begin
          out_q.steer_error <= work_q.steer_error;
          out_q.drive_total <= total_q;
          out_q.left_duty   <= left_duty;
          out_q.right_duty  <= right_duty;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/steering_error_pd_drive_top.sv =====
// ----------------------------------------------------------------------------
// steering_error_pd_drive_top: line-follower steering error and PD drive
// Classifies a left/right pickup pair into a steering error, runs a PD term
// on it and produces saturated wheel duties, with an APB register port.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake            Beat contents
//   in_*         in          in_valid / in_stall  left_sample, right_sample
//   out_*        out         out_valid / out_stall steer_error, drive_total,
//                                                 left_duty, right_duty
//   APB          in/out      psel/penable/pready  five configuration registers
//
// An input beat is classified in the cycle it is accepted and is queued for
// the arithmetic back end. The back end takes the entry from the queue, forms
// the gain products, runs the restoring divider for the derivative term,
// saturates the total and loads the output register, in that order; it takes
// no new entry until that beat is in the output register. The front keeps
// accepting while the queue has room, so up to two further beats may be taken
// while one is in arithmetic.
// Reset clears the error history, the side flags, the counters, the queue
// and the output valid; the registers return to their documented defaults.
// A stalled result holds in the output register; the back end waits and
// the queue fills, after which in_stall is raised.
//
// Registers sit at byte address 4*i: diff_threshold, blank_level, prop_gain,
// deriv_gain, base_speed. Writes to other addresses are dropped. They are
// meant to be written only while the block has no beat in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_error_pd_drive_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire sepd_pkg::in_item_t        in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output sepd_pkg::out_item_t            out_item_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [sepd_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import sepd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     cfg_write;

  logic  q_push, q_pop, q_full, q_empty;
  work_t q_push_data, q_pop_data;

  // The word index is taken from the upper address bits; byte offsets are
  // ignored.
  assign reg_idx   = reg_idx_e'(paddr[PaddrW-1:2]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_idx)
        REG_DIFF_THRESHOLD: cfg_d.diff_threshold = pwdata[7:0];
        REG_BLANK_LEVEL:    cfg_d.blank_level    = pwdata[7:0];
        REG_PROP_GAIN:      cfg_d.prop_gain      = pwdata[6:0];
        REG_DERIV_GAIN:     cfg_d.deriv_gain     = pwdata[5:0];
        REG_BASE_SPEED:     cfg_d.base_speed     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIFF_THRESHOLD: prdata = {24'd0, cfg_q.diff_threshold};
      REG_BLANK_LEVEL:    prdata = {24'd0, cfg_q.blank_level};
      REG_PROP_GAIN:      prdata = {25'd0, cfg_q.prop_gain};
      REG_DERIV_GAIN:     prdata = {26'd0, cfg_q.deriv_gain};
      REG_BASE_SPEED:     prdata = {24'd0, cfg_q.base_speed};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diff_threshold <= DiffThresholdRst;
      cfg_q.blank_level    <= BlankLevelRst;
      cfg_q.prop_gain      <= PropGainRst;
      cfg_q.deriv_gain     <= DerivGainRst;
      cfg_q.base_speed     <= BaseSpeedRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sepd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  sepd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  sepd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_data_i    (q_pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sepd_checker.sv =====
// ----------------------------------------------------------------------------
// sepd_checker: port-level checks for the steering error PD drive
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sepd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire sepd_pkg::out_item_t         out_item_o,
  input wire logic [31:0]                 prdata,
  input wire logic                        pready
);
  import sepd_pkg::*;

  // A stalled result is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // The classified error never takes the one code outside its range.
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.steer_error != -9'sd256)
    else $error("steering error out of range");

  // Leaving reset, the queue is empty and no result is pending.
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_stall_o && !out_valid_o)
    else $error("block not clean after reset");

  // Registers are at most eight bits wide and the port never waits.
  a_apb_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && prdata[31:8] == 24'd0)
    else $error("register read or ready malformed");

endmodule

bind steering_error_pd_drive_top sepd_checker u_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the steering error PD drive
// Sends left/right sample pairs through the input channel, predicts every
// result beat with an independent model of the classifier and PD arithmetic,
// and compares each result field by field. Registers are reprogrammed over
// the APB port between phases, under several sender and receiver idle rates.
// ----------------------------------------------------------------------------
module testbench;

  import sepd_pkg::*;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 9;
  // Far beyond the slowest legal run: about 1450 beats, plus the long receiver
  // hold-off and register traffic.
  localparam int CycleLimit    = 1000000;
  localparam int SettleCycles  = 40;
  localparam int HoldOffCycles = 400;
  localparam int PhaseBeats    = 195;
  localparam int HoldOffBeats  = 60;
  localparam int NumPhases     = 8;
  localparam int MaxReports    = 40;
  localparam int DutyMax       = 255;
  localparam int SampleMax     = 255;
  localparam int TotalMax      = 32767;
  localparam int TotalMin      = -32768;
  localparam logic [15:0]        StepCountMax = 16'hFFFF;
  // An address in the register window that maps to no register.
  localparam logic [RegIdxW-1:0] RegUnmapped  = 3'd5;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals of the block
  // --------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  steering_error_pd_drive_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_item_t    pair_queue[$];      // sample pairs waiting to be offered
  out_item_t   drive_expected[$];  // predicted result beats, oldest first
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        long_stall   = 1'b0;
  int          fail_count   = 0;
  int          cycle_count  = 0;
  event        long_stall_go;

  // Shadow of the configuration and of the steering history, kept at the
  // widths the block itself uses.
  cfg_t              shadow_cfg;
  logic signed [8:0] held_err;
  logic signed [8:0] prior_err;
  logic              seen_left;
  logic              seen_right;
  logic [15:0]       steps_now;
  logic [15:0]       steps_before;

  // --------------------------------------------------------------------------
  // Prediction of one result beat from one accepted sample pair. The error
  // cases are tried in order: centred, lost to the right, lost to the left,
  // left high, right high, and otherwise the held error stands.
  // --------------------------------------------------------------------------
  function automatic out_item_t predict_drive(input in_item_t beat);
    int        lft, rgt, diff, thr, blank, err, dvs, deriv, total, lval, rval;
    logic      in_band;
    out_item_t res;
    lft     = int'(beat.left_sample);
    rgt     = int'(beat.right_sample);
    diff    = lft - rgt;
    thr     = int'(shadow_cfg.diff_threshold);
    blank   = int'(shadow_cfg.blank_level);
    in_band = ((diff < 0) ? -diff : diff) < thr;
    if (in_band && lft > blank && rgt > blank) begin
      err = 0;
    end else if (in_band && seen_right) begin
      err = int'(ErrLostRight);
    end else if (in_band && seen_left) begin
      err = int'(ErrLostLeft);
    end else if (diff > thr) begin
      err        = diff - thr;
      seen_left  = 1'b1;
      seen_right = 1'b0;
    end else if (-diff > thr) begin
      err        = diff + thr;
      seen_right = 1'b1;
      seen_left  = 1'b0;
    end else begin
      err = int'(held_err);
    end

    // A new error value starts a fresh interval; the one just ended is kept
    // so that the derivative spans the last two intervals.
    if (err != int'(held_err)) begin
      prior_err    = held_err;
      steps_before = steps_now;
      steps_now    = 16'd1;
    end

    dvs   = int'(steps_now) + int'(steps_before);
    deriv = 0;
    if (dvs != 0) begin
      deriv = (int'(shadow_cfg.deriv_gain) * (err - int'(prior_err))) / dvs;
    end
    total = int'(shadow_cfg.prop_gain) * err + deriv;
    if (total > TotalMax) total = TotalMax;
    if (total < TotalMin) total = TotalMin;

    held_err = 9'(err);
    if (steps_now != StepCountMax) steps_now = steps_now + 16'd1;

    lval = total - int'(shadow_cfg.base_speed);
    rval = total + int'(shadow_cfg.base_speed);
    res.steer_error = 9'(err);
    res.drive_total = 16'(total);
    res.left_duty   = 8'((lval > 0) ? 0 : ((lval < -DutyMax) ? DutyMax : -lval));
    res.right_duty  = 8'((rval > DutyMax) ? DutyMax : ((rval < 0) ? 0 : rval));
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (fail_count < MaxReports) $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_drive_beat(input out_item_t got);
    out_item_t want;
    if (drive_expected.size() == 0) begin
      report_mismatch("result beat with nothing expected");
    end else begin
      want = drive_expected.pop_front();
      if (got.steer_error !== want.steer_error)
        report_mismatch($sformatf("steer_error got %0d want %0d",
                                  got.steer_error, want.steer_error));
      if (got.drive_total !== want.drive_total)
        report_mismatch($sformatf("drive_total got %0d want %0d",
                                  got.drive_total, want.drive_total));
      if (got.left_duty !== want.left_duty)
        report_mismatch($sformatf("left_duty got %0d want %0d",
                                  got.left_duty, want.left_duty));
      if (got.right_duty !== want.right_duty)
        report_mismatch($sformatf("right_duty got %0d want %0d",
                                  got.right_duty, want.right_duty));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the pending sample pairs, one beat at a time. A beat that
  // is stalled is held unchanged; when it is taken, its result is predicted
  // there and then, so predictions follow the order of acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) drive_expected.push_back(predict_drive(in_item_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pair_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_item_i  <= pair_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes result beats and stalls at random, or throughout a long
  // hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_drive_beat(out_item_o);
      out_stall_i <= long_stall || ($urandom_range(99) < rx_stall_pct);
    end
  end

  // The long hold-off runs in its own process, counted in clock cycles, so
  // that the sender keeps offering beats while the block backs up.
  initial begin
    forever begin
      @(long_stall_go);
      long_stall <= 1'b1;
      repeat (HoldOffCycles) @(posedge clk_i);
      long_stall <= 1'b0;
    end
  end

  // A run that hangs ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Register access and phase control
  // --------------------------------------------------------------------------
  // One APB write: a setup phase, then an access phase held until pready.
  // The shadow copy follows once the write has landed.
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DIFF_THRESHOLD: shadow_cfg.diff_threshold = val[7:0];
      REG_BLANK_LEVEL:    shadow_cfg.blank_level    = val[7:0];
      REG_PROP_GAIN:      shadow_cfg.prop_gain      = val[6:0];
      REG_DERIV_GAIN:     shadow_cfg.deriv_gain     = val[5:0];
      REG_BASE_SPEED:     shadow_cfg.base_speed     = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_cfg(input cfg_t c);
    write_reg(REG_DIFF_THRESHOLD, 32'(c.diff_threshold));
    write_reg(REG_BLANK_LEVEL,    32'(c.blank_level));
    write_reg(REG_PROP_GAIN,      32'(c.prop_gain));
    write_reg(REG_DERIV_GAIN,     32'(c.deriv_gain));
    write_reg(REG_BASE_SPEED,     32'(c.base_speed));
  endtask

  // Waits until every queued pair has been taken and every predicted beat
  // has come back, then lets the back end run dry.
  task automatic settle();
    while (pair_queue.size() != 0 || in_valid_i || drive_expected.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_pair(input int lft, input int rgt);
    in_item_t p;
    p.left_sample  = 8'(lft);
    p.right_sample = 8'(rgt);
    pair_queue.push_back(p);
  endtask

  function automatic cfg_t roll_config();
    cfg_t c;
    c.diff_threshold = 8'($urandom_range(40));
    c.blank_level    = 8'($urandom_range(140));
    c.prop_gain      = 7'($urandom_range(127));
    c.deriv_gain     = 6'($urandom_range(63));
    c.base_speed     = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic int clip_sample(input int v);
    return (v < 0) ? 0 : ((v > SampleMax) ? SampleMax : v);
  endfunction

  // Random pairs are weighted towards the interesting regions: the edges of
  // the dead band (including a difference exactly at the threshold), pairs
  // inside the band near the blank level so that the lost-line cases fire,
  // repeats of the last pair so that error intervals grow, and the corners.
  function automatic in_item_t draw_pair(input in_item_t prev);
    int       pick, lft, rgt, off;
    in_item_t p;
    pick = $urandom_range(99);
    lft  = $urandom_range(SampleMax);
    rgt  = $urandom_range(SampleMax);
    if (pick < 30) begin
      // Uniform over the whole input space.
    end else if (pick < 60) begin
      off = int'(shadow_cfg.diff_threshold) + int'($urandom_range(4)) - 2;
      if ($urandom_range(1) != 0) off = -off;
      rgt = clip_sample(lft - off);
    end else if (pick < 75) begin
      lft = clip_sample(int'(shadow_cfg.blank_level) + int'($urandom_range(6)) - 3);
      rgt = clip_sample(lft + int'($urandom_range(2)) - 1);
    end else if (pick < 90) begin
      return prev;
    end else begin
      lft = ($urandom_range(1) != 0) ? SampleMax : 0;
      rgt = ($urandom_range(1) != 0) ? SampleMax : 0;
    end
    p.left_sample  = 8'(lft);
    p.right_sample = 8'(rgt);
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t     c;
    in_item_t p;
    int       phase;
    int       beats;

    shadow_cfg.diff_threshold = DiffThresholdRst;
    shadow_cfg.blank_level    = BlankLevelRst;
    shadow_cfg.prop_gain      = PropGainRst;
    shadow_cfg.deriv_gain     = DerivGainRst;
    shadow_cfg.base_speed     = BaseSpeedRst;
    held_err     = '0;
    prior_err    = '0;
    seen_left    = 1'b0;
    seen_right   = 1'b0;
    steps_now    = '0;
    steps_before = '0;
    p            = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A write to an address with no register behind it must change nothing.
    write_reg(RegUnmapped, 32'hFFFF_FFFF);

    // Directed beats under the reset settings: centred, below blank with no
    // side seen, hard left and right, both lost-line cases, differences equal
    // to the threshold, the smallest offsets and full scale on both sides.
    queue_pair(100, 100); queue_pair(0, 0);     queue_pair(255, 0);
    queue_pair(0, 255);   queue_pair(10, 10);   queue_pair(200, 0);
    queue_pair(5, 5);     queue_pair(103, 100); queue_pair(100, 103);
    queue_pair(104, 100); queue_pair(100, 104); queue_pair(255, 255);
    settle();

    // Full gains and a mid base speed: the total saturates both ways and the
    // duties clip at both ends.
    c.diff_threshold = 8'd3;
    c.blank_level    = 8'd20;
    c.prop_gain      = 7'd127;
    c.deriv_gain     = 6'd63;
    c.base_speed     = 8'd128;
    program_cfg(c);
    queue_pair(255, 0);   queue_pair(255, 0);   queue_pair(0, 255);
    queue_pair(0, 255);   queue_pair(255, 0);   queue_pair(128, 128);
    queue_pair(0, 0);     queue_pair(1, 0);     queue_pair(255, 255);
    queue_pair(0, 255);   queue_pair(0, 1);
    settle();

    // Random phases, each with its own settings and idle pattern. The sender
    // pauses between phases until every expected beat has arrived.
    for (phase = 0; phase < NumPhases; phase++) begin
      c     = roll_config();
      beats = PhaseBeats;
      case (phase)
        0: begin
          tx_idle_pct <= 0;  rx_stall_pct <= 0;
        end
        1: begin
          // Lowest settings: no dead band, no blanking, no gain, no base.
          c = '0;
          tx_idle_pct <= 79; rx_stall_pct <= 0;
        end
        2: begin
          // Highest settings: the dead band covers almost everything.
          c.diff_threshold = 8'd255;
          c.blank_level    = 8'd255;
          c.prop_gain      = 7'd127;
          c.deriv_gain     = 6'd63;
          c.base_speed     = 8'd255;
          tx_idle_pct <= 0;  rx_stall_pct <= 79;
        end
        3: begin
          tx_idle_pct <= 26; rx_stall_pct <= 26;
        end
        4: begin
          // The receiver holds off for a long stretch while beats keep
          // coming, so the queue fills and the input stalls.
          beats = HoldOffBeats;
          tx_idle_pct <= 0;  rx_stall_pct <= 0;
        end
        5: begin
          c.diff_threshold = 8'd1;
          c.prop_gain      = 7'd127;
          c.deriv_gain     = 6'd63;
          tx_idle_pct <= 79; rx_stall_pct <= 0;
        end
        6: begin
          tx_idle_pct <= 0;  rx_stall_pct <= 79;
        end
        default: begin
          tx_idle_pct <= 0;  rx_stall_pct <= 0;
        end
      endcase
      program_cfg(c);
      if (phase == 4) -> long_stall_go;
      repeat (beats) begin
        p = draw_pair(p);
        pair_queue.push_back(p);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== steering_error_pd_drive_top.f =====
rtl/core/sepd_pkg.sv
rtl/core/sepd_front.sv
rtl/core/sepd_queue.sv
rtl/core/sepd_back.sv
rtl/core/steering_error_pd_drive_top.sv
rtl/core/sepd_checker.sv
dv/testbench.sv
